/* src/qrs_pkg.sv */
// Package for the quadratic root solver: payload structs, status codes, sizes.
// Used by quadratic_root_solver_core; no dependencies.
package qrs_pkg;

  localparam int unsigned FIELD_W = 32;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_NO_REAL  = 2'd1,
    STATUS_A_ZERO   = 2'd2,
    STATUS_OVERFLOW = 2'd3
  } status_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] coef_a;
    logic signed [FIELD_W-1:0] coef_b;
    logic signed [FIELD_W-1:0] coef_c;
  } coef_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] root_plus;
    logic signed [FIELD_W-1:0] root_minus;
    logic [1:0]                solve_status;
  } roots_t;

endpackage

/* src/quadratic_root_solver_core.sv */
// Quadratic root solver top: discriminant, pipelined sqrt, two pipelined dividers.
// Accepts one item per cycle while the output is not stalled.
// The sqrt and divider stages are fully pipelined, one bit each.
// A stall freezes the whole pipe; output register holds the result until taken.
// Synchronous active-high reset clears all valid bits; payload regs not reset.
module quadratic_root_solver_core #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  qrs_pkg::coef_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output qrs_pkg::roots_t out_data
);
  localparam int unsigned DW    = DATA_WIDTH;
  localparam int unsigned PW    = 2 * DW;        // product width
  localparam int unsigned RAD_W = 2 * DW + 4;    // discriminant, even width
  localparam int unsigned ROOT_W = DW + 2;
  localparam int unsigned NW    = DW + 2;        // |N| width
  localparam int unsigned QNUM_W = NW + FRAC_BITS;
  localparam int unsigned DEN_W = DW + 1;
  localparam int unsigned SIDE_W = 4;            // neg_p, neg_m, status 2b

  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // ---- stage 1: sign-extend coefficients
  logic               v1;
  logic signed [DW:0] a1, b1, c1;
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
    end
    if (adv) begin
      a1 <= {in_data.coef_a[DW-1], in_data.coef_a[DW-1:0]};
      b1 <= {in_data.coef_b[DW-1], in_data.coef_b[DW-1:0]};
      c1 <= {in_data.coef_c[DW-1], in_data.coef_c[DW-1:0]};
    end
  end

  // ---- stage 2: products b^2 and a*c (one multiplier each)
  logic               v2;
  logic [PW-1:0]      bb2, ac2;
  logic               ac_neg2;
  logic signed [DW:0] a2, b2;
  logic [DW:0]        ma1, mb1, mc1;
  always_comb begin
    ma1 = a1[DW] ? -a1 : a1;
    mb1 = b1[DW] ? -b1 : b1;
    mc1 = c1[DW] ? -c1 : c1;
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
    if (adv) begin
      bb2     <= PW'(mb1 * mb1);
      ac2     <= PW'(ma1 * mc1);
      ac_neg2 <= a1[DW] ^ c1[DW];
      a2      <= a1;
      b2      <= b1;
    end
  end

  // ---- stage 3: discriminant and early status
  logic               v3;
  logic [RAD_W-1:0]   d3;
  logic [1:0]         st3;
  logic signed [DW:0] a3, b3;
  logic [RAD_W:0]     dpos, dneg;
  always_comb begin
    dpos = (RAD_W+1)'(bb2) + ((RAD_W+1)'(ac2) << 2);
    dneg = (RAD_W+1)'(bb2) - ((RAD_W+1)'(ac2) << 2);
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
    if (adv) begin
      a3 <= a2;
      b3 <= b2;
      if (a2 == '0) begin
        st3 <= qrs_pkg::STATUS_A_ZERO;
        d3  <= '0;
      end else if (!ac_neg2 && ac2 != '0 && dneg[RAD_W]) begin
        st3 <= qrs_pkg::STATUS_NO_REAL;
        d3  <= '0;
      end else begin
        st3 <= qrs_pkg::STATUS_OK;
        d3  <= (ac_neg2 || ac2 == '0) ? dpos[RAD_W-1:0] : dneg[RAD_W-1:0];
      end
    end
  end

  // ---- sqrt pipeline, one root bit per stage
  logic               sv   [ROOT_W+1];
  logic [RAD_W-1:0]   srem [ROOT_W+1];
  logic [ROOT_W-1:0]  sroot[ROOT_W+1];
  logic signed [DW:0] sa   [ROOT_W+1];
  logic signed [DW:0] sb   [ROOT_W+1];
  logic [1:0]         sst  [ROOT_W+1];
  always_comb begin
    sv[0] = v3; srem[0] = d3; sroot[0] = '0;
    sa[0] = a3; sb[0] = b3; sst[0] = st3;
  end
  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    logic [RAD_W-1:0]  rn;
    logic [ROOT_W-1:0] qn;
    qrs_sqrt_stage #(.RAD_W(RAD_W), .ROOT_W(ROOT_W), .BIT_POS(ROOT_W-1-k)) u_stage (
      .rem_in(srem[k]), .root_in(sroot[k]), .rem_out(rn), .root_out(qn)
    );
    always_ff @(posedge clk) begin
      if (rst) begin
        sv[k+1] <= 1'b0;
      end else if (adv) begin
        sv[k+1] <= sv[k];
      end
      if (adv) begin
        srem[k+1] <= rn; sroot[k+1] <= qn;
        sa[k+1] <= sa[k]; sb[k+1] <= sb[k]; sst[k+1] <= sst[k];
      end
    end
  end

  // ---- stage N: numerators and divider operands
  logic signed [NW:0] np, nm;
  logic               vn;
  logic [QNUM_W-1:0]  nump, numm;
  logic [DEN_W-1:0]   den;
  logic [1:0]         stn;
  logic               negp, negm;
  logic signed [DW:0] af;
  logic [NW:0]        mnp, mnm;
  always_comb begin
    af  = sa[ROOT_W];
    np  = -(NW+1)'(sb[ROOT_W]) + (NW+1)'(sroot[ROOT_W]);
    nm  = -(NW+1)'(sb[ROOT_W]) - (NW+1)'(sroot[ROOT_W]);
    mnp = np[NW] ? -np : np;
    mnm = nm[NW] ? -nm : nm;
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      vn <= 1'b0;
    end else if (adv) begin
      vn <= sv[ROOT_W];
    end
    if (adv) begin
      nump <= QNUM_W'(mnp[NW-1:0]) << FRAC_BITS;
      numm <= QNUM_W'(mnm[NW-1:0]) << FRAC_BITS;
      den  <= DEN_W'(af[DW] ? -af : af) << 1;
      negp <= np[NW] ^ af[DW];
      negm <= nm[NW] ^ af[DW];
      stn  <= sst[ROOT_W];
    end
  end

  logic              dv_p, dv_m;
  logic [QNUM_W-1:0] qp, qm;
  logic [SIDE_W-1:0] sidep, sidem;
  qrs_divider #(.NUM_W(QNUM_W), .DEN_W(DEN_W), .SIDE_W(SIDE_W)) u_div_plus (
    .clk(clk), .rst(rst), .adv(adv), .in_valid(vn), .num_in(nump), .den_in(den),
    .side_in({negp, negm, stn}), .out_valid(dv_p), .quot_out(qp), .side_out(sidep)
  );
  qrs_divider #(.NUM_W(QNUM_W), .DEN_W(DEN_W), .SIDE_W(SIDE_W)) u_div_minus (
    .clk(clk), .rst(rst), .adv(adv), .in_valid(vn), .num_in(numm), .den_in(den),
    .side_in({negp, negm, stn}), .out_valid(dv_m), .quot_out(qm), .side_out(sidem)
  );

  // ---- output: saturate, sign, status
  localparam logic [QNUM_W-1:0] LIM = QNUM_W'(1) << (DW - 1);
  logic [DW-1:0]          rp, rm;
  logic                   op, om;
  logic [1:0]             sto;
  logic signed [DW-1:0]   rpv, rmv;
  always_comb begin
    op = sidep[3] ? (qp > LIM) : (qp > LIM - 1'b1);
    om = sidep[2] ? (qm > LIM) : (qm > LIM - 1'b1);
    rpv = op ? (sidep[3] ? DW'(LIM) : DW'(LIM - 1'b1)) : DW'(qp);
    rmv = om ? (sidep[2] ? DW'(LIM) : DW'(LIM - 1'b1)) : DW'(qm);
    rp  = sidep[3] ? -rpv : rpv;
    rm  = sidep[2] ? -rmv : rmv;
    sto = sidem[1:0];
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dv_p & dv_m;
    end
    if (adv) begin
      if (sto != qrs_pkg::STATUS_OK) begin
        out_data.root_plus    <= '0;
        out_data.root_minus   <= '0;
        out_data.solve_status <= sto;
      end else begin
        out_data.root_plus    <= qrs_pkg::FIELD_W'(signed'(rp));
        out_data.root_minus   <= qrs_pkg::FIELD_W'(signed'(rm));
        out_data.solve_status <= (op || om) ? qrs_pkg::STATUS_OVERFLOW
                                            : qrs_pkg::STATUS_OK;
      end
    end
  end
endmodule

/* src/qrs_sqrt_stage.sv */
// One stage of the pipelined restoring square root (one result bit per stage).
// Depends on qrs_pkg only by convention; no package items used here.
module qrs_sqrt_stage #(
  parameter int unsigned RAD_W = 68,
  parameter int unsigned ROOT_W = 34,
  parameter int unsigned BIT_POS = 0
) (
  input  logic [RAD_W-1:0]  rem_in,
  input  logic [ROOT_W-1:0] root_in,
  output logic [RAD_W-1:0]  rem_out,
  output logic [ROOT_W-1:0] root_out
);
  logic [RAD_W-1:0] trial;
  logic [RAD_W:0]   diff;

  // trial = (2*root + 2^bit) << bit, where root holds the bits already decided
  always_comb begin
    trial = (RAD_W'(root_in) << (BIT_POS + 1)) | (RAD_W'(1) << (2 * BIT_POS));
    diff  = {1'b0, rem_in} - {1'b0, trial};
    if (!diff[RAD_W]) begin
      rem_out  = diff[RAD_W-1:0];
      root_out = root_in | (ROOT_W'(1) << BIT_POS);
    end else begin
      rem_out  = rem_in;
      root_out = root_in;
    end
  end
endmodule

/* src/qrs_divider.sv */
// Pipelined unsigned restoring divider with one quotient bit per stage.
// Holds its own valid-tagged stages; stall via the shared advance enable.
module qrs_divider #(
  parameter int unsigned NUM_W = 48,
  parameter int unsigned DEN_W = 33,
  parameter int unsigned SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  num_in,
  input  logic [DEN_W-1:0]  den_in,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [NUM_W-1:0]  quot_out,
  output logic [SIDE_W-1:0] side_out
);
  // stage s holds remainder, remaining numerator bits shifted, quotient so far
  logic              vld  [NUM_W+1];
  logic [DEN_W-1:0]  rem  [NUM_W+1];
  logic [NUM_W-1:0]  nsh  [NUM_W+1];
  logic [NUM_W-1:0]  quo  [NUM_W+1];
  logic [DEN_W-1:0]  den  [NUM_W+1];
  logic [SIDE_W-1:0] side [NUM_W+1];

  always_comb begin
    vld[0]  = in_valid;
    rem[0]  = '0;
    nsh[0]  = num_in;
    quo[0]  = '0;
    den[0]  = den_in;
    side[0] = side_in;
  end

  for (genvar s = 0; s < NUM_W; s++) begin : g_stage
    logic [DEN_W:0] cur;
    logic [DEN_W:0] dif;
    always_comb begin
      cur = {rem[s], nsh[s][NUM_W-1]};
      dif = cur - {1'b0, den[s]};
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (adv) begin
        vld[s+1] <= vld[s];
      end
      if (adv) begin
        // cur < 2*den so the remainder always fits DEN_W bits
        rem[s+1]  <= dif[DEN_W] ? cur[DEN_W-1:0] : dif[DEN_W-1:0];
        quo[s+1]  <= {quo[s][NUM_W-2:0], ~dif[DEN_W]};
        nsh[s+1]  <= {nsh[s][NUM_W-2:0], 1'b0};
        den[s+1]  <= den[s];
        side[s+1] <= side[s];
      end
    end
  end

  assign out_valid = vld[NUM_W];
  assign quot_out  = quo[NUM_W];
  assign side_out  = side[NUM_W];
endmodule
